>>> hw/rtl/psfp_pkg.sv
package psfp_pkg;

    // Frame marker bytes
    localparam logic [7:0] BYTE_HEADER  = 8'hAA;
    localparam logic [7:0] BYTE_COMMAND = 8'hC0;
    localparam logic [7:0] BYTE_TAIL    = 8'hAB;

    // Six payload bytes followed by the checksum byte
    localparam int CAPTURE_COUNT = 7;
    localparam int CAPTURE_IDX_W = $clog2(CAPTURE_COUNT);

    typedef struct packed {
        logic        checksum_ok;
        logic [15:0] fine_particles_tenths;
        logic [15:0] coarse_particles_tenths;
    } result_t;

endpackage

>>> hw/rtl/psfp_frame_tracker.sv
module psfp_frame_tracker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_take,
    input  logic [7:0]           rx_byte,
    output logic                 result_push,
    output psfp_pkg::result_t    result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMMAND,
        ST_CAPTURE,
        ST_TAIL
    } state_t;

    localparam logic [psfp_pkg::CAPTURE_IDX_W-1:0] CAP_LAST =
        psfp_pkg::CAPTURE_IDX_W'(psfp_pkg::CAPTURE_COUNT - 1);

    state_t                            state_reg, state_next;
    logic [psfp_pkg::CAPTURE_IDX_W-1:0] cap_idx_reg, cap_idx_next;
    logic [7:0]                        captured_reg [psfp_pkg::CAPTURE_COUNT];
    logic [7:0]                        payload_sum;

    always_comb
    begin
        state_next   = state_reg;
        cap_idx_next = cap_idx_reg;
        if (byte_take)
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    state_next = (rx_byte == psfp_pkg::BYTE_HEADER) ? ST_COMMAND : ST_IDLE;
                end
                ST_COMMAND:
                begin
                    cap_idx_next = '0;
                    state_next = (rx_byte == psfp_pkg::BYTE_COMMAND) ? ST_CAPTURE : ST_IDLE;
                end
                ST_CAPTURE:
                begin
                    cap_idx_next = cap_idx_reg + 1'b1;
                    if (cap_idx_reg == CAP_LAST)
                    begin
                        state_next = ST_TAIL;
                    end
                end
                ST_TAIL:
                begin
                    state_next = ST_IDLE;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cap_idx_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cap_idx_reg <= cap_idx_next;
        end
    end

    // Capture storage: payload only, no reset
    always_ff @(posedge clk)
    begin
        if (byte_take && state_reg == ST_CAPTURE)
        begin
            captured_reg[cap_idx_reg] <= rx_byte;
        end
    end

    assign payload_sum = captured_reg[0] + captured_reg[1] + captured_reg[2]
                       + captured_reg[3] + captured_reg[4] + captured_reg[5];

    assign result_push = byte_take && state_reg == ST_TAIL
                         && rx_byte == psfp_pkg::BYTE_TAIL;

    assign result.checksum_ok             = (payload_sum == captured_reg[6]);
    assign result.fine_particles_tenths   = {captured_reg[1], captured_reg[0]};
    assign result.coarse_particles_tenths = {captured_reg[3], captured_reg[2]};

`ifndef SYNTHESIS
    // A frame result follows the command byte by exactly eight words
    a_push_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
        result_push |-> $past(state_reg) == ST_CAPTURE || $past(state_reg) == ST_TAIL)
        else $error("result pushed without a full capture");
    a_capture_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CAPTURE |-> cap_idx_reg <= CAP_LAST)
        else $error("capture index out of range");
    a_tail_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_take && state_reg == ST_CAPTURE && cap_idx_reg == CAP_LAST)
        |=> state_reg == ST_TAIL)
        else $error("tail state not reached after last capture");
`endif

endmodule

>>> hw/rtl/psfp_result_buffer.sv
module psfp_result_buffer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  psfp_pkg::result_t    push_data,
    output logic                 space,
    output logic                 out_valid,
    input  logic                 out_ready,
    output psfp_pkg::result_t    out_data
);

    logic              out_valid_reg, skid_valid_reg;
    psfp_pkg::result_t out_reg, skid_reg;
    logic              pop;

    assign pop   = out_valid_reg && out_ready;
    assign space = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (!out_valid_reg)
            begin
                out_valid_reg <= push;
            end
            else if (pop)
            begin
                out_valid_reg  <= skid_valid_reg || push;
                skid_valid_reg <= skid_valid_reg && push;
            end
            else
            begin
                // Stalled output: park a new word in the skid register
                skid_valid_reg <= skid_valid_reg || push;
            end
        end
    end

    // Payload: no reset
    always_ff @(posedge clk)
    begin
        priority if (!out_valid_reg)
        begin
            out_reg <= push_data;
        end
        else if (pop)
        begin
            out_reg  <= skid_valid_reg ? skid_reg : push_data;
            skid_reg <= push_data;
        end
        else
        begin
            if (push)
            begin
                skid_reg <= push_data;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with empty output register");
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("push into full result buffer");
    a_stall_holds_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg && $stable(out_reg))
        else $error("stalled result changed");
`endif

endmodule

>>> hw/rtl/particulate_sensor_frame_parser.sv
// Particulate sensor frame parser. Takes one received serial byte per input
// word and follows the ten-byte sensor frame: header 0xAA, command 0xC0, six
// payload bytes, a checksum byte and tail 0xAB. Bytes other than the header
// are dropped while hunting; a wrong command byte or a missing tail returns
// the parser to hunting with no result. On a good tail one result word is
// issued: checksum_ok is set when the modulo-256 sum of the six payload bytes
// equals the checksum byte (a result is issued on a mismatch too), and the
// PM2.5 and PM10 readings are the little-endian payload words 0-1 and 2-3,
// in tenths of a microgram per cubic metre. Rate: one byte per clock cycle
// while in_ready is high; the result word is registered into the output
// register, or into the skid register while the output is stalled. A
// two-word result buffer (output register plus skid register) keeps the
// input open while a result waits; in_ready drops only when both hold words.
module particulate_sensor_frame_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        checksum_ok,
    output logic [15:0] fine_particles_tenths,
    output logic [15:0] coarse_particles_tenths
);

    logic              byte_take;
    logic              result_push;
    logic              buf_space;
    psfp_pkg::result_t frame_result;
    psfp_pkg::result_t out_data;

    // Accept a byte whenever the result buffer can take a word
    assign in_ready  = buf_space;
    assign byte_take = in_valid && in_ready;

    // Frame state machine, capture registers and checksum compare
    psfp_frame_tracker u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_take   (byte_take),
        .rx_byte     (rx_byte),
        .result_push (result_push),
        .result      (frame_result)
    );

    // Output register with skid stage: hold results while the sink stalls
    psfp_result_buffer u_result_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (result_push),
        .push_data (frame_result),
        .space     (buf_space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign checksum_ok             = out_data.checksum_ok;
    assign fine_particles_tenths   = out_data.fine_particles_tenths;
    assign coarse_particles_tenths = out_data.coarse_particles_tenths;

endmodule

>>> tb/tb_particulate_sensor_frame_parser.sv
module tb_particulate_sensor_frame_parser;
    timeunit 1ns;
    timeprecision 1ps;

    // Run sizing. The random part stops once this many frame-related bytes
    // are queued; idle noise bytes are not counted toward it.
    localparam int RANDOM_BYTES    = 1550;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int REPORT_LIMIT    = 10;
    localparam int PAYLOAD_COUNT   = psfp_pkg::CAPTURE_COUNT - 1;

    // Parser positions of the predictor: hunting, header seen, capturing
    // payload and checksum, then waiting for the tail.
    localparam logic [3:0] POS_IDLE          = 4'd0;
    localparam logic [3:0] POS_HEADER        = 4'd1;
    localparam logic [3:0] POS_CAPTURE_FIRST = 4'd2;
    localparam logic [3:0] POS_CAPTURE_LAST  = 4'd8;
    localparam logic [3:0] POS_TAIL          = 4'd9;

    // Shapes of the random byte sequences
    typedef enum int {
        SEQ_FRAME,
        SEQ_NO_TAIL,
        SEQ_BAD_COMMAND,
        SEQ_CUT_SHORT,
        SEQ_NOISE
    } seq_kind_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        checksum_ok;
    logic [15:0] fine_particles_tenths;
    logic [15:0] coarse_particles_tenths;

    // Bytes still to be offered, and readings predicted but not yet seen
    logic [7:0]        serial_bytes[$];
    psfp_pkg::result_t pending_readings[$];
    psfp_pkg::result_t oldest_reading;

    // Predictor state: position in the frame and the captured bytes
    logic [3:0]  frame_pos = POS_IDLE;
    logic [7:0]  frame_bytes [psfp_pkg::CAPTURE_COUNT];

    int          bytes_total    = 0;
    int          bytes_accepted = 0;
    int          readings_seen  = 0;
    int          reading_errors = 0;
    int          cycle_count    = 0;
    int          send_gap       = 0;
    int          send_calm      = 0;
    int          recv_stall     = 0;
    int          recv_calm      = 0;
    logic        hold_off       = 1'b0;

    particulate_sensor_frame_parser i_dut (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .in_valid                (in_valid),
        .in_ready                (in_ready),
        .rx_byte                 (rx_byte),
        .out_valid               (out_valid),
        .out_ready               (out_ready),
        .checksum_ok             (checksum_ok),
        .fine_particles_tenths   (fine_particles_tenths),
        .coarse_particles_tenths (coarse_particles_tenths)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    // Idle length in cycles: mostly none, often short, now and then long.
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Payload content, biased toward the extremes and the marker values so
    // that markers inside a frame get exercised as plain data.
    function automatic logic [7:0] data_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return psfp_pkg::BYTE_HEADER;
            3:       return psfp_pkg::BYTE_TAIL;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Any byte but the given one; often a header byte, which must not
    // restart a frame when it lands on the command or tail slot.
    function automatic logic [7:0] byte_except(logic [7:0] avoid);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0)
            b = psfp_pkg::BYTE_HEADER;
        if (b == avoid)
            b = ~avoid;
        return b;
    endfunction

    // Advance the predicted parser by one accepted byte and queue the reading
    // that a good tail produces.
    function automatic void track_frame_byte(logic [7:0] b);
        psfp_pkg::result_t reading;
        logic [7:0]        sum;
        sum = 8'h00;
        if (frame_pos == POS_HEADER)
        begin
            // Anything but the command byte drops back to hunting, header too
            frame_pos = (b == psfp_pkg::BYTE_COMMAND) ? POS_CAPTURE_FIRST : POS_IDLE;
        end
        else if (frame_pos >= POS_CAPTURE_FIRST && frame_pos <= POS_CAPTURE_LAST)
        begin
            // Every value is data here, markers included
            frame_bytes[frame_pos - POS_CAPTURE_FIRST] = b;
            frame_pos = frame_pos + 4'd1;
        end
        else if (frame_pos == POS_TAIL)
        begin
            frame_pos = POS_IDLE;
            if (b == psfp_pkg::BYTE_TAIL)
            begin
                for (int i = 0; i < PAYLOAD_COUNT; i++)
                    sum = sum + frame_bytes[i];
                reading.checksum_ok             = (sum == frame_bytes[PAYLOAD_COUNT]);
                reading.fine_particles_tenths   = {frame_bytes[1], frame_bytes[0]};
                reading.coarse_particles_tenths = {frame_bytes[3], frame_bytes[2]};
                pending_readings.push_back(reading);
            end
        end
        else
        begin
            // Hunting: only a header byte gets the parser going
            frame_pos = (b == psfp_pkg::BYTE_HEADER) ? POS_HEADER : POS_IDLE;
        end
    endfunction

    // Append one random sequence of the given shape to the byte stream.
    task automatic queue_sequence(seq_kind_t kind);
        logic [7:0] payload [psfp_pkg::CAPTURE_COUNT];
        logic [7:0] sum;
        int         cut;
        sum = 8'h00;
        if (kind == SEQ_NOISE)
        begin
            repeat ($urandom_range(1, 5))
                serial_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        serial_bytes.push_back(psfp_pkg::BYTE_HEADER);
        if (kind == SEQ_BAD_COMMAND)
        begin
            serial_bytes.push_back(byte_except(psfp_pkg::BYTE_COMMAND));
            return;
        end
        serial_bytes.push_back(psfp_pkg::BYTE_COMMAND);
        for (int i = 0; i < PAYLOAD_COUNT; i++)
        begin
            payload[i] = data_byte();
            sum = sum + payload[i];
        end
        // Mostly a matching checksum, otherwise whatever comes up
        payload[PAYLOAD_COUNT] = ($urandom_range(0, 2) != 0) ? sum : data_byte();
        cut = (kind == SEQ_CUT_SHORT) ? $urandom_range(0, psfp_pkg::CAPTURE_COUNT - 1)
                                      : psfp_pkg::CAPTURE_COUNT;
        for (int i = 0; i < cut; i++)
            serial_bytes.push_back(payload[i]);
        if (kind == SEQ_FRAME)
            serial_bytes.push_back(psfp_pkg::BYTE_TAIL);
        else if (kind == SEQ_NO_TAIL)
            serial_bytes.push_back(byte_except(psfp_pkg::BYTE_TAIL));
    endtask

    // Sender: offer the next queued byte after a random gap, and hold valid
    // and the byte steady until the word is taken. Accepted bytes feed the
    // predictor right at the accepting edge.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                track_frame_byte(rx_byte);
                bytes_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (serial_bytes.size() > 0)
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= serial_bytes.pop_front();
                    if (send_calm > 0)
                    begin
                        send_calm--;
                    end
                    else
                    begin
                        // Now and then run back to back for a while
                        if ($urandom_range(0, 49) == 0)
                            send_calm = $urandom_range(20, 80);
                        send_gap = gap_length();
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall at random, with calm stretches of steady ready, and
    // drop ready entirely while a long hold-off is in force.
    always @(posedge clk)
    begin
        if (!rst_n || hold_off)
        begin
            out_ready <= 1'b0;
        end
        else if (recv_stall > 0)
        begin
            recv_stall--;
            out_ready <= 1'b0;
        end
        else if (recv_calm > 0)
        begin
            recv_calm--;
            out_ready <= 1'b1;
        end
        else
        begin
            if ($urandom_range(0, 49) == 0)
                recv_calm = $urandom_range(20, 80);
            recv_stall = gap_length();
            out_ready <= (recv_stall == 0);
            if (recv_stall > 0)
                recv_stall--;
        end
    end

    // Long hold-offs on the result side while bytes keep coming, so the
    // result buffer fills and the parser has to stall its input.
    initial
    begin
        for (int round = 0; round < 2; round++)
        begin
            while (readings_seen < 10 + 40 * round)
                @(posedge clk);
            hold_off <= 1'b1;
            repeat (HOLD_OFF_CYCLES)
                @(posedge clk);
            hold_off <= 1'b0;
        end
    end

    // Checker: each accepted result word against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            readings_seen++;
            if (pending_readings.size() == 0)
            begin
                reading_errors++;
                if (reading_errors <= REPORT_LIMIT)
                    $display("%0t: result with none expected: ok=%0b pm25=%h pm10=%h",
                             $realtime, checksum_ok, fine_particles_tenths,
                             coarse_particles_tenths);
            end
            else
            begin
                oldest_reading = pending_readings.pop_front();
                if (checksum_ok !== oldest_reading.checksum_ok
                    || fine_particles_tenths !== oldest_reading.fine_particles_tenths
                    || coarse_particles_tenths !== oldest_reading.coarse_particles_tenths)
                begin
                    reading_errors++;
                    if (reading_errors <= REPORT_LIMIT)
                        $display("%0t: result mismatch: ok=%0b/%0b pm25=%h/%h pm10=%h/%h",
                                 $realtime, checksum_ok, oldest_reading.checksum_ok,
                                 fine_particles_tenths,
                                 oldest_reading.fine_particles_tenths,
                                 coarse_particles_tenths,
                                 oldest_reading.coarse_particles_tenths);
                end
            end
        end
    end

    // Watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("particulate_sensor_frame_parser regression: fail");
            $finish;
        end
    end

    initial
    begin
        int         counted;
        int         before_size;
        int         roll;
        seq_kind_t  kind;
        counted = 0;

        // Directed opening: noise while hunting, a header followed by a
        // second header in the command slot (then a stray command byte that
        // must be ignored), an all-ones frame with a good checksum, and a
        // frame carrying markers as payload with a checksum mismatch.
        serial_bytes = '{8'h00, 8'hFF,
                         psfp_pkg::BYTE_HEADER, psfp_pkg::BYTE_HEADER,
                         psfp_pkg::BYTE_COMMAND,
                         psfp_pkg::BYTE_HEADER, psfp_pkg::BYTE_COMMAND,
                         8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFA,
                         psfp_pkg::BYTE_TAIL,
                         psfp_pkg::BYTE_HEADER, psfp_pkg::BYTE_COMMAND,
                         psfp_pkg::BYTE_HEADER, psfp_pkg::BYTE_TAIL, 8'h00, 8'h00,
                         psfp_pkg::BYTE_TAIL, psfp_pkg::BYTE_HEADER,
                         8'h00, psfp_pkg::BYTE_TAIL};

        // Random part: mostly well-formed frames with random content, the
        // rest missing tails, bad commands, cut-off frames and noise.
        while (counted < RANDOM_BYTES)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
                kind = SEQ_FRAME;
            else if (roll < 80)
                kind = SEQ_NO_TAIL;
            else if (roll < 87)
                kind = SEQ_BAD_COMMAND;
            else if (roll < 92)
                kind = SEQ_CUT_SHORT;
            else
                kind = SEQ_NOISE;
            before_size = serial_bytes.size();
            queue_sequence(kind);
            if (kind != SEQ_NOISE)
                counted += serial_bytes.size() - before_size;
        end
        bytes_total = serial_bytes.size();

        // Reset once, then let the sender and receiver run
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every byte to be taken, then for every reading to show
        while (bytes_accepted < bytes_total)
            @(posedge clk);
        while (pending_readings.size() != 0)
            @(posedge clk);
        // Catch any stray result word trailing the last one
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (reading_errors == 0 && pending_readings.size() == 0)
            $display("particulate_sensor_frame_parser regression: pass");
        else
            $display("particulate_sensor_frame_parser regression: fail");
        $finish;
    end

endmodule

>>> particulate_sensor_frame_parser.f
hw/rtl/psfp_pkg.sv
hw/rtl/psfp_frame_tracker.sv
hw/rtl/psfp_result_buffer.sv
hw/rtl/particulate_sensor_frame_parser.sv
tb/tb_particulate_sensor_frame_parser.sv
